// ===== rtl/pfrgba_pkg.sv =====
package pfrgba_pkg;

    // channel sample formats
    typedef enum logic [1:0] {
        FMT_8BIT  = 2'd0,
        FMT_16BIT = 2'd1,
        FMT_FLOAT = 2'd2,
        FMT_OTHER = 2'd3
    } fmt_t;

    // configuration register indexes
    localparam logic CFG_SAMPLE_FORMAT = 1'b0;
    localparam logic CFG_CHANNEL_COUNT = 1'b1;

    localparam int RAW_W   = 32;
    localparam int CHAN_W  = 8;
    localparam int COUNT_W = 3;
    localparam int CFG_W   = 3;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;
    localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'hFF;

endpackage

// ===== rtl/pfrgba_chan_conv.sv =====
module pfrgba_chan_conv (
    input  pfrgba_pkg::fmt_t            fmt,
    input  logic [pfrgba_pkg::RAW_W-1:0]  raw,
    output logic [pfrgba_pkg::CHAN_W-1:0] conv
);
    import pfrgba_pkg::*;

    // 16-bit path: v*255/65535 == v/257, quotient is v>>8 or one less
    logic [7:0]  q16;
    logic [16:0] q16_x257;
    logic [7:0]  res16;

    assign q16      = raw[15:8];
    assign q16_x257 = {1'b0, q16, 8'd0} + {9'd0, q16};
    assign res16    = (q16_x257 > {1'b0, raw[15:0]}) ? q16 - 8'd1 : q16;

    // float path fields
    logic        f_sign;
    logic [7:0]  f_exp;
    logic [22:0] f_frac;
    logic [23:0] f_mant;
    logic [31:0] prod;
    logic [5:0]  prod_len;
    logic [3:0]  rnd_shift;
    logic [31:0] rbit_mask;
    logic [31:0] sticky_mask;
    logic        rnd_inc;
    logic [23:0] q_trunc;
    logic [24:0] q_rnd;
    logic [7:0]  scale_sh;
    logic [7:0]  total_sh;
    logic [24:0] int_part;
    logic [7:0]  res_f;

    assign f_sign = raw[31];
    assign f_exp  = raw[30:23];
    assign f_frac = raw[22:0];
    assign f_mant = (f_exp == 8'd0) ? {1'b0, f_frac} : {1'b1, f_frac};

    // mantissa times 255 as shift and subtract
    assign prod = {f_mant, 8'd0} - {8'd0, f_mant};

    // leading one position of the product
    always_comb begin
        prod_len = 6'd0;
        for (int i = 0; i < 32; i++) begin
            if (prod[i]) begin
                prod_len = 6'(i + 1);
            end
        end
    end

    // round to 24 significant bits, nearest even
    assign rnd_shift   = (prod_len > 6'd24) ? 4'(prod_len - 6'd24) : 4'd0;
    assign rbit_mask   = (rnd_shift == 4'd0) ? 32'd0 : (32'd1 << (rnd_shift - 4'd1));
    assign sticky_mask = rbit_mask - 32'd1;
    assign q_trunc     = 24'(prod >> rnd_shift);
    assign rnd_inc     = (rnd_shift != 4'd0) && (|(prod & rbit_mask))
                         && ((|(prod & sticky_mask)) || q_trunc[0]);
    assign q_rnd       = {1'b0, q_trunc} + {24'd0, rnd_inc};

    // weight of the rounded product, then truncate to the integer part
    assign scale_sh = (f_exp == 8'd0) ? 8'd149 : 8'd150 - f_exp;
    assign total_sh = scale_sh - {4'd0, rnd_shift};
    assign int_part = (total_sh >= 8'd25) ? 25'd0 : (q_rnd >> total_sh);

    always_comb begin
        priority if (f_exp == 8'hFF && f_frac != 23'd0) begin
            res_f = 8'd0;
        end else if (f_exp == 8'd0 && f_frac == 23'd0) begin
            res_f = 8'd0;
        end else if (f_sign) begin
            res_f = 8'd0;
        end else if (f_exp >= 8'd127) begin
            res_f = CHAN_MAX;
        end else if (int_part > 25'd255) begin
            res_f = CHAN_MAX;
        end else begin
            res_f = int_part[7:0];
        end
    end

    // format select
    always_comb begin
        unique case (fmt)
            FMT_16BIT: conv = res16;
            FMT_FLOAT: conv = res_f;
            FMT_8BIT:  conv = raw[7:0];
            FMT_OTHER: conv = raw[7:0];
            default:   conv = raw[7:0];
        endcase
    end

endmodule

// ===== rtl/pixel_format_to_rgba8.sv =====
// Pixel format converter: raw channel values in, one RGBA8 pixel out.
// Input stream s_*: one pixel per item, four 32-bit raw channels in s_tdata
// and the end-of-image flag in s_tlast. Output stream m_*: one RGBA8 pixel
// per item, red in the lowest byte, flag copied to m_tlast.
// Configuration: cfg_wr_en with cfg_index 0 writes sample_format (0 8-bit,
// 1 16-bit integer, 2 float, 3 as 8-bit), index 1 writes channel_count.
// Write configuration only while no pixel is in flight.
// Throughput: one pixel per cycle while the receiver does not stall. An
// accepted item waits in the input register, then the result register
// takes the whole conversion of all four channels. Reset (aresetn low,
// synchronous) empties both stages and sets 8-bit format with four
// channels. When the receiver stalls, the result holds in the output
// register and one more pixel is still taken into the input register;
// s_tready drops only when both stages are full.
module pixel_format_to_rgba8 (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [pfrgba_pkg::CFG_W-1:0] cfg_data,
    // input pixels
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [127:0] s_tdata, // chan_red, chan_green, chan_blue, chan_alpha
    input  logic        s_tlast,  // last_pixel
    // output pixels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // red, green, blue, alpha
    output logic        m_tlast   // last_out
);
    import pfrgba_pkg::*;

    fmt_t               fmt_reg;
    logic [COUNT_W-1:0] count_reg;

    logic         in_valid_reg;
    logic [127:0] in_data_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    logic [31:0]  out_data_reg;
    logic         out_last_reg;

    logic         out_adv;
    logic [7:0]   conv_r, conv_g, conv_b, conv_a;
    logic [31:0]  pixel_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg   <= FMT_8BIT;
            count_reg <= COUNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SAMPLE_FORMAT: fmt_reg   <= fmt_t'(cfg_data[1:0]);
                CFG_CHANNEL_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                default:           fmt_reg   <= fmt_reg;
            endcase
        end
    end

    // pipeline handshake
    assign out_adv  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // per channel conversion
    pfrgba_chan_conv u_conv_r (.fmt(fmt_reg), .raw(in_data_reg[31:0]),   .conv(conv_r));
    pfrgba_chan_conv u_conv_g (.fmt(fmt_reg), .raw(in_data_reg[63:32]),  .conv(conv_g));
    pfrgba_chan_conv u_conv_b (.fmt(fmt_reg), .raw(in_data_reg[95:64]),  .conv(conv_b));
    pfrgba_chan_conv u_conv_a (.fmt(fmt_reg), .raw(in_data_reg[127:96]), .conv(conv_a));

    // absent green, blue or alpha: color 0, alpha opaque; red is always converted
    assign pixel_next = {
        (count_reg > 3'd3) ? conv_a : CHAN_MAX,
        (count_reg > 3'd2) ? conv_b : 8'd0,
        (count_reg > 3'd1) ? conv_g : 8'd0,
        conv_r
    };

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && out_adv) begin
            out_data_reg <= pixel_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // both stages full and stalled: no new item may enter
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline full and stalled");

    // an accepted item lands in the input stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted item lost");

    // a held input item moves to the output when the output frees up
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_adv) |=> out_valid_reg)
        else $error("item not moved to result register");

    // missing alpha reads opaque
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_adv && count_reg <= 3'd3) |=> (m_tdata[31:24] == CHAN_MAX))
        else $error("absent alpha not opaque");

    // missing green and blue read zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_adv && count_reg <= 3'd1) |=> (m_tdata[23:8] == 16'd0))
        else $error("absent color channel not zero");

endmodule
